>>> src/mig_pkg.sv
// package: types and constants for the 4x4 gauss-jordan inverse unit
package mig_pkg;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_INIT,
        ST_PSCAN,
        ST_RECIP,
        ST_SCALE,
        ST_ELIM_F,
        ST_ELIM,
        ST_EMIT
    } mig_state_t;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_MAC
    } mig_op_t;

    // request to the shared multiply unit
    typedef struct packed {
        logic    start;
        mig_op_t op;
    } mig_mul_ctl_t;

endpackage

>>> src/mig_divider.sv
// file: restoring bit-serial divider for the pivot reciprocal
module mig_divider #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [WORD_BITS-1:0] divisor,
    input  logic                 neg,
    output logic                 done,
    output logic [WORD_BITS-1:0] quotient
);
    import mig_pkg::*;

    localparam int NB = 2 * FRAC_BITS + 1;
    localparam int CB = $clog2(NB + 1);
    localparam int XB = ((NB > WORD_BITS) ? NB : WORD_BITS) + 1;
    localparam logic [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic [XB-1:0] WMAXX = XB'(WMAX);

    logic [NB-1:0]        num_reg, num_next;
    logic [WORD_BITS:0]   rem_reg, rem_next;
    logic [NB-1:0]        quo_reg, quo_next;
    logic [CB-1:0]        cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic [WORD_BITS-1:0] div_reg, div_next;
    logic                 neg_reg, neg_next;
    logic [WORD_BITS:0]   shifted;
    logic [XB-1:0]        qx;

    always_comb
    begin
        num_next = num_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        div_next = div_reg;
        neg_next = neg_reg;
        shifted = {rem_reg[WORD_BITS-1:0], num_reg[NB-1]};
        if (start)
        begin
            num_next = {1'b1, {(NB-1){1'b0}}};
            rem_next = '0;
            quo_next = '0;
            cnt_next = CB'(NB);
            busy_next = 1'b1;
            div_next = divisor;
            neg_next = neg;
        end
        else if (busy_reg)
        begin
            num_next = num_reg << 1;
            if (shifted >= {1'b0, div_reg})
            begin
                rem_next = shifted - {1'b0, div_reg};
                quo_next = {quo_reg[NB-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[NB-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CB'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
        neg_reg <= neg_next;
    end

    logic done_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= busy_reg && (cnt_reg == CB'(1));
    end
    assign done = done_reg;

    assign qx = XB'(quo_reg);

    // saturate to signed word with sign of pivot
    always_comb
    begin
        if (neg_reg)
        begin
            if (qx > WMAXX + XB'(1))
                quotient = ~WMAX;
            else
                quotient = WORD_BITS'(-qx);
        end
        else
        begin
            if (qx > WMAXX)
                quotient = WMAX;
            else
                quotient = WORD_BITS'(qx);
        end
    end
endmodule

>>> src/mig_mul.sv
// file: shared fixed-point multiply (floored, saturated) with optional add
module mig_mul #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mig_pkg::mig_mul_ctl_t        ctl,
    input  logic signed [WORD_BITS-1:0]  a,
    input  logic signed [WORD_BITS-1:0]  b,
    input  logic signed [WORD_BITS-1:0]  addend,
    output logic                         done,
    output logic signed [WORD_BITS-1:0]  result
);
    import mig_pkg::*;

    localparam int PB = 2 * WORD_BITS;
    localparam logic signed [PB+1:0] WMAXP = (PB+2)'({1'b0, {(WORD_BITS-1){1'b1}}});
    localparam logic signed [PB+1:0] WMINP = -WMAXP - 1;

    logic signed [PB-1:0]   prod;
    logic signed [PB-1:0]   prod_reg;
    logic signed [WORD_BITS-1:0] add_reg;
    logic                   mac_reg;
    logic                   v_reg;
    logic signed [PB+1:0]   sh;
    logic signed [PB+1:0]   sum;
    logic signed [PB+1:0]   m;

    assign prod = a * b;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod;
        add_reg <= addend;
        mac_reg <= (ctl.op == OP_MAC);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else
            v_reg <= ctl.start;
    end

    always_comb
    begin
        sh = (PB+2)'(prod_reg >>> FRAC_BITS);
        if (sh > WMAXP)
            m = WMAXP;
        else if (sh < WMINP)
            m = WMINP;
        else
            m = sh;
        sum = mac_reg ? m + (PB+2)'(add_reg) : m;
        if (sum > WMAXP)
            result = WORD_BITS'(WMAXP);
        else if (sum < WMINP)
            result = WORD_BITS'(WMINP);
        else
            result = WORD_BITS'(sum);
    end
    assign done = v_reg;
endmodule

>>> src/matrix4_inverse_gauss_jordan_unit.sv
// file: top level of the gauss-jordan matrix inverse unit
// Inverts a DIM x DIM signed fixed-point matrix (Q16.16 at default
// parameters) by Gauss-Jordan elimination with partial pivoting. Elements
// enter one transaction at a time in row-major order; after the last one the
// unit stalls its input while a small sequencer drives one shared multiplier
// and one bit-serial divider over an augmented [A|I] memory of DIM x 2*DIM
// words held in registers. A singular matrix stops at the first failed pivot
// scan. The DIM*DIM results then leave one transaction per cycle while
// out_stall is low, with inverse_ok; a singular matrix (no pivot above
// pivot_threshold) yields the identity with inverse_ok low. last_element
// marks the final result of each matrix. pivot_threshold may be written only
// while the unit is idle.
module matrix4_inverse_gauss_jordan_unit #(
    parameter int DIM       = 4,
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [30:0]                 cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [WORD_BITS-1:0] matrix_element,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [WORD_BITS-1:0] inverse_element,
    output logic                        inverse_ok,
    output logic                        last_element
);
    import mig_pkg::*;

    localparam int COLS = 2 * DIM;
    localparam int RB   = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int CB   = $clog2(COLS);
    localparam int NB   = $clog2(DIM * DIM + 1);
    localparam logic signed [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] ONE =
        (FRAC_BITS >= WORD_BITS - 1) ? WMAX : WORD_BITS'(64'd1 << FRAC_BITS);

    // augmented store, flops indexed by row/col
    logic signed [WORD_BITS-1:0] aug_reg [DIM][COLS];
    logic [RB-1:0] ord_reg [DIM];

    mig_state_t state_reg, state_next;
    logic [NB-1:0] cnt_reg;        // load / emit counter
    logic [RB-1:0] col_reg;        // pivot column, load / emit column
    logic [RB-1:0] row_reg;        // scan / elimination row, load / emit row
    logic [CB-1:0] j_reg;          // column within row
    logic          wait_reg;       // multiplier or divider in flight
    logic [RB-1:0] sel_reg;
    logic          found_reg;
    logic [WORD_BITS:0] best_reg;
    logic signed [WORD_BITS-1:0] recip_reg;
    logic signed [WORD_BITS-1:0] factor_reg;
    logic          ok_reg;
    logic [30:0]   thr_reg;
    logic          div_start;
    logic [RB-1:0] pwin;           // winning scan position

    // shared units
    mig_mul_ctl_t mctl;
    logic signed [WORD_BITS-1:0] ma, mb, madd, mres;
    logic mdone, ddone;
    logic [WORD_BITS-1:0] dq;
    logic signed [WORD_BITS-1:0] piv;
    logic [WORD_BITS-1:0] pmag;
    logic [WORD_BITS:0] cmag;
    logic signed [WORD_BITS-1:0] cval;

    assign cval = aug_reg[ord_reg[row_reg]][CB'(col_reg)];
    assign cmag = cval[WORD_BITS-1] ? (WORD_BITS+1)'(-{cval[WORD_BITS-1], cval})
                                    : {1'b0, cval};
    assign piv  = aug_reg[ord_reg[col_reg]][CB'(col_reg)];
    assign pmag = piv[WORD_BITS-1] ? WORD_BITS'(-piv) : piv;
    assign pwin = (cmag > best_reg) ? row_reg : sel_reg;

    mig_mul #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_mul (
        .clk(clk), .rst_n(rst_n), .ctl(mctl), .a(ma), .b(mb), .addend(madd),
        .done(mdone), .result(mres)
    );

    mig_divider #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .divisor(pmag),
        .neg(piv[WORD_BITS-1]), .done(ddone), .quotient(dq)
    );

    // multiplier operand selection
    always_comb
    begin
        mctl.start = 1'b0;
        mctl.op = OP_MUL;
        ma = aug_reg[ord_reg[col_reg]][j_reg];
        mb = recip_reg;
        madd = aug_reg[ord_reg[row_reg]][j_reg];
        if (state_reg == ST_SCALE && !wait_reg)
            mctl.start = 1'b1;
        if (state_reg == ST_ELIM && !wait_reg)
        begin
            mctl.start = 1'b1;
            mctl.op = OP_MAC;
            mb = factor_reg;
        end
    end

    assign div_start = (state_reg == ST_RECIP) && !wait_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
                if (in_valid && cnt_reg == NB'(DIM * DIM - 1))
                    state_next = ST_INIT;
            ST_INIT:
                state_next = ST_PSCAN;
            ST_PSCAN:
                if (row_reg == RB'(DIM - 1))
                begin
                    if (found_reg || cmag > best_reg)
                        state_next = ST_RECIP;
                    else
                        state_next = ST_EMIT;
                end
            ST_RECIP:
                if (ddone)
                    state_next = ST_SCALE;
            ST_SCALE:
                if (mdone && j_reg == CB'(COLS - 1))
                    state_next = ST_ELIM_F;
            ST_ELIM_F:
                if (row_reg == col_reg)
                begin
                    if (col_reg == RB'(DIM - 1) || (DIM == 1))
                        state_next = (col_reg == RB'(DIM - 1)) ? ST_EMIT : ST_PSCAN;
                    else
                        state_next = ST_ELIM_F;
                end
                else
                    state_next = ST_ELIM;
            ST_ELIM:
                if (mdone && j_reg == CB'(COLS - 1))
                begin
                    if (row_reg == RB'(DIM - 1) ||
                        (row_reg == RB'(DIM - 2) && col_reg == RB'(DIM - 1)))
                        state_next = (col_reg == RB'(DIM - 1)) ? ST_EMIT : ST_PSCAN;
                    else
                        state_next = ST_ELIM_F;
                end
            ST_EMIT:
                if (!out_stall && cnt_reg == NB'(DIM * DIM - 1))
                    state_next = ST_LOAD;
            default:
                state_next = ST_LOAD;
        endcase
    end

    // outputs
    always_comb
    begin
        in_stall = (state_reg != ST_LOAD);
        out_valid = (state_reg == ST_EMIT);
        last_element = (cnt_reg == NB'(DIM * DIM - 1));
        inverse_ok = ok_reg;
        if (ok_reg)
            inverse_element = aug_reg[ord_reg[row_reg]][CB'(DIM) + CB'(col_reg)];
        else
            inverse_element = (row_reg == col_reg) ? ONE : '0;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cnt_reg <= '0;
            col_reg <= '0;
            row_reg <= '0;
            j_reg <= '0;
            wait_reg <= 1'b0;
            found_reg <= 1'b0;
            ok_reg <= 1'b0;
            thr_reg <= 31'd66;
            for (int r = 0; r < DIM; r++)
                ord_reg[r] <= RB'(r);
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                thr_reg <= cfg_wdata;
            case (state_reg)
                ST_LOAD:
                    if (in_valid)
                    begin
                        cnt_reg <= (cnt_reg == NB'(DIM * DIM - 1)) ? '0 : cnt_reg + 1'b1;
                        col_reg <= (col_reg == RB'(DIM - 1)) ? '0 : col_reg + 1'b1;
                        if (col_reg == RB'(DIM - 1))
                            row_reg <= (row_reg == RB'(DIM - 1)) ? '0 : row_reg + 1'b1;
                    end
                ST_INIT:
                begin
                    for (int r = 0; r < DIM; r++)
                        ord_reg[r] <= RB'(r);
                    col_reg <= '0;
                    row_reg <= '0;
                    found_reg <= 1'b0;
                    ok_reg <= 1'b1;
                end
                ST_PSCAN:
                begin
                    if (row_reg == RB'(DIM - 1))
                    begin
                        if (found_reg || cmag > best_reg)
                        begin
                            // swap winner into pivot position
                            if (pwin != col_reg)
                            begin
                                ord_reg[col_reg] <= ord_reg[pwin];
                                ord_reg[pwin] <= ord_reg[col_reg];
                            end
                        end
                        else
                        begin
                            ok_reg <= 1'b0;
                            row_reg <= '0;
                            col_reg <= '0;
                        end
                        found_reg <= 1'b0;
                    end
                    else
                    begin
                        if (cmag > best_reg)
                            found_reg <= 1'b1;
                        row_reg <= row_reg + 1'b1;
                    end
                    wait_reg <= 1'b0;
                end
                ST_RECIP:
                begin
                    wait_reg <= ~ddone;
                    j_reg <= '0;
                end
                ST_SCALE:
                begin
                    wait_reg <= ~mdone;
                    if (mdone)
                    begin
                        j_reg <= (j_reg == CB'(COLS - 1)) ? '0 : j_reg + 1'b1;
                        if (j_reg == CB'(COLS - 1))
                            row_reg <= (col_reg == '0) ? RB'(1) : '0;
                    end
                end
                ST_ELIM_F:
                begin
                    j_reg <= '0;
                    wait_reg <= 1'b0;
                    if (row_reg == col_reg)
                    begin
                        if (col_reg == RB'(DIM - 1))
                        begin
                            cnt_reg <= '0;
                            row_reg <= '0;
                            col_reg <= '0;
                        end
                        else
                        begin
                            col_reg <= col_reg + 1'b1;
                            row_reg <= col_reg + 1'b1;
                        end
                    end
                end
                ST_ELIM:
                begin
                    wait_reg <= ~mdone;
                    if (mdone)
                    begin
                        j_reg <= (j_reg == CB'(COLS - 1)) ? '0 : j_reg + 1'b1;
                        if (j_reg == CB'(COLS - 1))
                        begin
                            if (state_next == ST_PSCAN)
                            begin
                                col_reg <= col_reg + 1'b1;
                                row_reg <= col_reg + 1'b1;
                            end
                            else if (state_next == ST_EMIT)
                            begin
                                cnt_reg <= '0;
                                row_reg <= '0;
                                col_reg <= '0;
                            end
                            else
                                row_reg <= (row_reg + 1'b1 == col_reg) ? row_reg + RB'(2)
                                                                      : row_reg + 1'b1;
                        end
                    end
                end
                ST_EMIT:
                    if (!out_stall)
                    begin
                        cnt_reg <= (cnt_reg == NB'(DIM * DIM - 1)) ? '0 : cnt_reg + 1'b1;
                        col_reg <= (col_reg == RB'(DIM - 1)) ? '0 : col_reg + 1'b1;
                        if (col_reg == RB'(DIM - 1))
                            row_reg <= (row_reg == RB'(DIM - 1)) ? '0 : row_reg + 1'b1;
                    end
                default:
                    ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_LOAD:
                if (in_valid)
                    aug_reg[row_reg][CB'(col_reg)] <= matrix_element;
            ST_INIT:
            begin
                for (int r = 0; r < DIM; r++)
                    for (int c = 0; c < DIM; c++)
                        aug_reg[r][DIM + c] <= (r == c) ? ONE : '0;
                best_reg <= (WORD_BITS+1)'(thr_reg);
            end
            ST_PSCAN:
            begin
                if (row_reg == RB'(DIM - 1))
                    best_reg <= (WORD_BITS+1)'(thr_reg);
                else if (cmag > best_reg)
                begin
                    best_reg <= cmag;
                    sel_reg <= row_reg;
                end
            end
            ST_RECIP:
                if (ddone)
                    recip_reg <= dq;
            ST_SCALE:
                if (mdone)
                    aug_reg[ord_reg[col_reg]][j_reg] <=
                        (j_reg == CB'(col_reg)) ? ONE : mres;
            ST_ELIM_F:
                factor_reg <= (cval == ~WMAX) ? WMAX : -cval;
            ST_ELIM:
                if (mdone)
                    aug_reg[ord_reg[row_reg]][j_reg] <=
                        (j_reg == CB'(col_reg)) ? '0 : mres;
            default:
                ;
        endcase
    end
endmodule

>>> src/mig_checker.sv
// file: port-level checker for the gauss-jordan inverse unit
module mig_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        inverse_ok,
    input logic        last_element,
    input logic [31:0] inverse_element
);
    // no input accepted while results are being delivered
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open while results pending");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(inverse_element)
            && $stable(last_element))
        else $error("stalled result changed");

    // ok flag constant within one matrix
    a_ok_const: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_element |=> !out_valid || $stable(inverse_ok))
        else $error("ok flag changed within matrix");

    // after the last result input reopens
    a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && last_element |=> !out_valid && !in_stall)
        else $error("unit did not return to load");
endmodule

bind matrix4_inverse_gauss_jordan_unit mig_checker u_mig_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .inverse_ok(inverse_ok),
    .last_element(last_element), .inverse_element(inverse_element)
);
